/* src/vcp_pkg.sv */
// Shared types, opcodes and the operand-length table for the command stream parser.
`default_nettype none

package vcp_pkg;

  // Opcodes with a defined meaning
  localparam logic [7:0] OP_REG_WRITE  = 8'hA0;
  localparam logic [7:0] OP_WAIT_N     = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC  = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL   = 8'h63;
  localparam logic [7:0] OP_END_DATA   = 8'h66;
  localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
  localparam logic [7:0] OP_PCM_WRITE  = 8'h68;
  localparam logic [3:0] OP_SHORT_WAIT_HI = 4'h7;  // 0x70..0x7F
  localparam logic [7:0] OP_LEN4_FIRST = 8'hE1;

  // Byte that must follow a data-block or PCM-write opcode
  localparam logic [7:0] BLOCK_MARK = 8'h66;

  localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

  // Byte positions inside a command
  localparam logic [3:0] POS_OPCODE     = 4'd0;
  localparam logic [3:0] POS_FIRST      = 4'd1;
  localparam logic [3:0] POS_SECOND     = 4'd2;
  localparam logic [3:0] POS_SIZE_B0    = 4'd3;
  localparam logic [3:0] POS_SIZE_B1    = 4'd4;
  localparam logic [3:0] POS_SIZE_B2    = 4'd5;
  localparam logic [3:0] POS_SIZE_B3    = 4'd6;
  localparam logic [3:0] POS_PAYLOAD    = 4'd7;
  localparam logic [3:0] PCM_HEADER_LEN = 4'd11;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // How the back end forms wait_count
  typedef enum logic [2:0] {
    WSEL_NONE,
    WSEL_OPERANDS,
    WSEL_NTSC,
    WSEL_PAL,
    WSEL_SHORT
  } wait_sel_e;

  // One queued result in compact form
  typedef struct packed {
    kind_e      kind;
    wait_sel_e  wsel;
    logic [7:0] lo;
    logic [7:0] hi;
  } vcp_entry_t;

  function automatic logic [2:0] operand_len(input logic [7:0] op);
    logic [2:0] len;
    len = 3'd0;
    if ((op >= 8'h30 && op <= 8'h3F) || op == 8'h4F || op == 8'h50) begin
      len = 3'd1;
    end else if ((op >= 8'h40 && op <= 8'h4E) || (op >= 8'h51 && op <= 8'h61) ||
                 (op >= 8'hA0 && op <= 8'hBF)) begin
      len = 3'd2;
    end else if (op >= 8'hC0 && op <= 8'hE0) begin
      len = 3'd3;
    end else if (op >= OP_LEN4_FIRST) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* src/vgm_command_stream_parser.sv */
// Top level of the byte-serial sound-log command stream parser.
//
// Takes one command-stream byte per transfer on the s_axis side and groups the
// bytes into commands by the per-opcode operand length table. Each complete
// command gives at most one result transfer on the m_axis side: a chip register
// write (0xA0), a wait in 44.1 kHz samples (0x61, 0x62, 0x63, 0x70..0x7F) or an
// end-of-data mark (0x66); parsing carries on after end-of-data. Data blocks
// (0x67) and PCM RAM writes (0x68) are checked for their 0x66 mark and skipped,
// payload included. A missing mark yields one format-error result, after which
// the input keeps being accepted but is ignored until reset. The block takes one
// byte per clock cycle while s_axis_tready is high, updating the parse state as
// each byte is accepted. A result enters a queue of FifoDepth entries when the
// byte completing it is accepted and moves on into an output register when free;
// s_axis_tready drops only while that queue is full.
`default_nettype none

module vgm_command_stream_parser
  import vcp_pkg::*;
#(
  parameter int FifoDepth = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,

  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte

  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] reg_index, [15:8] reg_value,
                                      // [31:16] wait_count
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  vcp_entry_t  push_entry, head_entry;
  logic        push, pop, full, empty;
  kind_e       kind;
  logic [7:0]  reg_index, reg_value;
  logic [15:0] wait_count;

  // Front: framing and classification
  vcp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .full_i  (full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Queue decouples front stalls from sink backpressure
  vcp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back: field expansion and output register
  vcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_entry),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .kind_o       (kind),
    .reg_index_o  (reg_index),
    .reg_value_o  (reg_value),
    .wait_count_o (wait_count)
  );

  assign m_axis_tdata = {wait_count, reg_value, reg_index};
  assign m_axis_tuser = kind;

  a_fifo_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("queued result not moved to the output register");

endmodule

`default_nettype wire

/* src/vcp_front.sv */
// Front end: accepts stream bytes, tracks command framing and queues results.
`default_nettype none

module vcp_front
  import vcp_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  input  wire  [7:0] byte_i,
  input  wire        full_i,
  output logic       ready_o,
  output logic       push_o,
  output vcp_entry_t entry_o
);

  logic [7:0]  opcode_q, opcode_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  first_q, first_d;
  logic [31:0] skip_q, skip_d;
  logic        halted_q, halted_d;
  logic        accept;

  assign ready_o = ~full_i;
  assign accept  = valid_i & ready_o;

  always_comb begin
    opcode_d = opcode_q;
    pos_d    = pos_q;
    first_d  = first_q;
    skip_d   = skip_q;
    halted_d = halted_q;
    push_o   = 1'b0;
    entry_o  = '{kind: KIND_WRITE, wsel: WSEL_NONE, lo: 8'h00, hi: 8'h00};

    if (accept && !halted_q) begin
      if (pos_q == POS_OPCODE) begin
        opcode_d = byte_i;
        first_d  = 8'h00;
        skip_d   = 32'd0;
        if (byte_i == OP_DATA_BLOCK || byte_i == OP_PCM_WRITE ||
            operand_len(byte_i) != 3'd0) begin
          pos_d = POS_FIRST;
        end else begin
          case (byte_i)
            OP_WAIT_NTSC: begin
              push_o        = 1'b1;
              entry_o.kind  = KIND_WAIT;
              entry_o.wsel  = WSEL_NTSC;
            end
            OP_WAIT_PAL: begin
              push_o        = 1'b1;
              entry_o.kind  = KIND_WAIT;
              entry_o.wsel  = WSEL_PAL;
            end
            OP_END_DATA: begin
              push_o        = 1'b1;
              entry_o.kind  = KIND_END;
            end
            default: begin
              if (byte_i[7:4] == OP_SHORT_WAIT_HI) begin
                push_o       = 1'b1;
                entry_o.kind = KIND_WAIT;
                entry_o.wsel = WSEL_SHORT;
                entry_o.lo   = byte_i;
              end
            end
          endcase
        end
      end else if (opcode_q == OP_DATA_BLOCK || opcode_q == OP_PCM_WRITE) begin
        if (pos_q == POS_FIRST && byte_i != BLOCK_MARK) begin
          // missing mark: report once and stop until reset
          halted_d     = 1'b1;
          pos_d        = POS_OPCODE;
          push_o       = 1'b1;
          entry_o.kind = KIND_ERROR;
        end else if (opcode_q == OP_PCM_WRITE) begin
          pos_d = (pos_q >= PCM_HEADER_LEN) ? POS_OPCODE : pos_q + 4'd1;
        end else if (pos_q == POS_PAYLOAD) begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            pos_d = POS_OPCODE;
          end
        end else begin
          pos_d = pos_q + 4'd1;
          case (pos_q)
            POS_SIZE_B0: skip_d[7:0]   = byte_i;
            POS_SIZE_B1: skip_d[15:8]  = byte_i;
            POS_SIZE_B2: skip_d[23:16] = byte_i;
            POS_SIZE_B3: begin
              skip_d[31:24] = byte_i;
              pos_d = ({byte_i, skip_q[23:0]} == 32'd0) ? POS_OPCODE : POS_PAYLOAD;
            end
            default: ;
          endcase
        end
      end else begin
        if (pos_q == POS_FIRST) begin
          first_d = byte_i;
        end
        if (pos_q < {1'b0, operand_len(opcode_q)}) begin
          pos_d = pos_q + 4'd1;
        end else begin
          pos_d = POS_OPCODE;
          // both two-operand results complete on the second operand byte
          if (opcode_q == OP_REG_WRITE) begin
            push_o       = 1'b1;
            entry_o.kind = KIND_WRITE;
            entry_o.lo   = first_q;
            entry_o.hi   = byte_i;
          end else if (opcode_q == OP_WAIT_N) begin
            push_o       = 1'b1;
            entry_o.kind = KIND_WAIT;
            entry_o.wsel = WSEL_OPERANDS;
            entry_o.lo   = first_q;
            entry_o.hi   = byte_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcode_q <= 8'h00;
      pos_q    <= POS_OPCODE;
      first_q  <= 8'h00;
      skip_q   <= 32'd0;
      halted_q <= 1'b0;
    end else begin
      opcode_q <= opcode_d;
      pos_q    <= pos_d;
      first_q  <= first_d;
      skip_q   <= skip_d;
      halted_q <= halted_d;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  // a PCM write also walks through this position while counting its header
  a_payload_only_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == POS_PAYLOAD && opcode_q != OP_PCM_WRITE) |->
      (opcode_q == OP_DATA_BLOCK && skip_q != 32'd0))
    else $error("payload skip outside a data block");

endmodule

`default_nettype wire

/* src/vcp_fifo.sv */
// Small result queue between the parser front end and the output stage.
`default_nettype none

module vcp_fifo
  import vcp_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  vcp_entry_t entry_i,
  input  wire        pop_i,
  output vcp_entry_t head_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  vcp_entry_t     mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("write into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("read from an empty queue");

endmodule

`default_nettype wire

/* src/vcp_back.sv */
// Output stage: expands queued results into full fields and holds them for the sink.
`default_nettype none

module vcp_back
  import vcp_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         empty_i,
  input  vcp_entry_t  head_i,
  output logic        pop_o,
  output logic        valid_o,
  input  wire         ready_i,
  output kind_e       kind_o,
  output logic [7:0]  reg_index_o,
  output logic [7:0]  reg_value_o,
  output logic [15:0] wait_count_o
);

  logic        valid_q;
  kind_e       kind_q;
  logic [7:0]  index_q, index_d;
  logic [7:0]  value_q, value_d;
  logic [15:0] wait_q, wait_d;

  assign pop_o = ~empty_i & (~valid_q | ready_i);

  always_comb begin
    index_d = 8'h00;
    value_d = 8'h00;
    if (head_i.kind == KIND_WRITE) begin
      index_d = head_i.lo;
      value_d = head_i.hi;
    end
    case (head_i.wsel)
      WSEL_OPERANDS: wait_d = {head_i.hi, head_i.lo};
      WSEL_NTSC:     wait_d = WAIT_NTSC_SAMPLES;
      WSEL_PAL:      wait_d = WAIT_PAL_SAMPLES;
      WSEL_SHORT:    wait_d = {12'h000, head_i.lo[3:0]} + 16'd1;
      default:       wait_d = 16'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= head_i.kind;
      index_q <= index_d;
      value_q <= value_d;
      wait_q  <= wait_d;
    end
  end

  assign valid_o      = valid_q;
  assign kind_o       = kind_q;
  assign reg_index_o  = index_q;
  assign reg_value_o  = value_q;
  assign wait_count_o = wait_q;

endmodule

`default_nettype wire
